// ===== rtl/eprm_pkg.sv =====
// ----------------------------------------------------------------------------
// eprm_pkg
// Shared types and constants of the packet rate meter: field widths, register
// codes and reset values, sequencer states and the divider status bundle.
// ----------------------------------------------------------------------------
package eprm_pkg;

  // Field widths fixed by the stream format.
  localparam int LEN_W      = 19;
  localparam int TPS_W      = 32;
  localparam int ALPHA_W    = 17;
  localparam int ALPHA_FRAC = 16;
  localparam int RATE_W     = 48;
  localparam int PEND_P_W   = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Defaults for the top-level parameters.
  localparam int DEF_TIME_WIDTH = 48;
  localparam int DEF_RATE_FRAC  = 16;

  // Register reset values and the alpha value that means 1.0.
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
  localparam logic [TPS_W-1:0]   TPS_RESET   = 32'd1000000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMOOTHING = 1'b0,
    CFG_TPS       = 1'b1
  } eprm_cfg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_P,
    ST_DIV_D,
    ST_EMA0,
    ST_EMA1,
    ST_EMA2,
    ST_EMA3,
    ST_EMA4,
    ST_DONE
  } eprm_state_t;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } eprm_div_sts_t;

endpackage

// ===== rtl/eprm_div.sv =====
// ----------------------------------------------------------------------------
// eprm_div
// Radix-2 restoring divider, one quotient bit per cycle. The quotient
// saturates to the rate width.
// ----------------------------------------------------------------------------
module eprm_div #(
  parameter int NUM_W = 51,
  parameter int DEN_W = 48
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [DEN_W-1:0]          den,
  output eprm_pkg::eprm_div_sts_t   sts,
  output logic [eprm_pkg::RATE_W-1:0] quot
);
  import eprm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [NUM_W-1:0] dq_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Shift in the next dividend bit and try the subtraction.
  assign trial = {rem_r, dq_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  // Step counter and completion flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Partial remainder and the dividend register that collects quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      dq_r  <= {dq_r[NUM_W-2:0], ge};
    end
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign quot     = (|dq_r[NUM_W-1:RATE_W]) ? {RATE_W{1'b1}} : dq_r[RATE_W-1:0];

endmodule

// ===== rtl/ema_packet_rate_meter.sv =====
// One item is in work at a time: an arrival is taken only in the idle state, so the meter
// takes no new arrival until the last one's result beat is loaded. An arrival that updates
// the rates runs the shared radix-2 divider twice, once for each sample; a first arrival
// after tick zero also runs it twice but sets the rates directly, and every other arrival
// skips the divider. Reset is synchronous and active low; it restores the register defaults
// and clears the meter state and the output valid flag.
// ----------------------------------------------------------------------------
// ema_packet_rate_meter
// Exponentially smoothed packet and data rate meter. Each arrival beat
// carries a timestamp and a length; each result beat carries both rates and
// the folded packet and bit totals.
// ----------------------------------------------------------------------------
module ema_packet_rate_meter #(
  parameter int TIME_WIDTH     = eprm_pkg::DEF_TIME_WIDTH,
  parameter int RATE_FRAC_BITS = eprm_pkg::DEF_RATE_FRAC
) (
  input  logic clk,
  input  logic rst_n,
  // Arrival channel. in_tdata: arrival_time, packet_length_bits, zero fill.
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [((TIME_WIDTH + eprm_pkg::LEN_W + 7) / 8) * 8 - 1:0] in_tdata,
  // Result channel. out_tdata: packet_rate, data_rate, total_packets, total_bits.
  output logic out_tvalid,
  input  logic out_tready,
  output logic [4 * eprm_pkg::RATE_W - 1:0] out_tdata,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [eprm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [eprm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import eprm_pkg::*;

  localparam int PROD_W = LEN_W + TPS_W;
  localparam int NUM_W  = (TPS_W + RATE_FRAC_BITS > PROD_W) ? TPS_W + RATE_FRAC_BITS : PROD_W;
  localparam int MUL_W  = RATE_W + ALPHA_W;
  localparam logic [RATE_W-1:0] ONE_RATE = RATE_W'(1) << RATE_FRAC_BITS;

  eprm_state_t state_r, state_nxt;

  // Configuration registers.
  logic [ALPHA_W-1:0] wgt_r;
  logic [TPS_W-1:0]   tps_r;

  // Meter state.
  logic                  seen_r;
  logic [TIME_WIDTH-1:0] last_r;
  logic [RATE_W-1:0]     rate_p_r, rate_b_r;
  logic [PEND_P_W-1:0]   pend_p_r;
  logic [RATE_W-1:0]     pend_b_r, sum_p_r, sum_b_r;

  // Per-item working registers.
  logic [TIME_WIDTH-1:0] now_r, elapsed_r;
  logic [LEN_W-1:0]      len_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  direct_r;
  logic [RATE_W-1:0]     samp_p_r, samp_d_r;
  logic [MUL_W-1:0]      mprod_r, acc_r;

  // Output register.
  logic              out_tvalid_r;
  logic [RATE_W-1:0] out_rp_r, out_rb_r, out_sp_r, out_sb_r;

  // Combinational helpers.
  logic [TPS_W-1:0]      tps_eff;
  logic [ALPHA_W-1:0]    a_eff, a_inv;
  logic [TIME_WIDTH-1:0] elapsed_c;
  logic                  later;
  logic                  to_div;
  logic                  div_start;
  logic [NUM_W-1:0]      div_num;
  logic [TIME_WIDTH-1:0] div_den;
  eprm_div_sts_t         div_sts;
  logic [RATE_W-1:0]     div_q;
  logic [RATE_W-1:0]     mul_a;
  logic [ALPHA_W-1:0]    mul_b;
  logic [MUL_W-1:0]      mix;
  logic                  load_out;
  logic [RATE_W:0]       sum_p_add, sum_b_add, pend_b_add;

  assign tps_eff   = (tps_r == '0) ? TPS_W'(1) : tps_r;
  assign a_eff     = (wgt_r > ALPHA_ONE) ? ALPHA_ONE : wgt_r;
  assign a_inv     = ALPHA_ONE - a_eff;
  assign later     = (now_r > last_r);
  assign elapsed_c = seen_r ? (now_r - last_r) : now_r;
  assign to_div    = seen_r ? later : (now_r != '0);
  assign mix       = acc_r + mprod_r;

  // Saturating sums for the totals and the pending bit count.
  assign sum_p_add  = {1'b0, sum_p_r} + (RATE_W + 1)'(pend_p_r);
  assign sum_b_add  = {1'b0, sum_b_r} + {1'b0, pend_b_r};
  assign pend_b_add = {1'b0, pend_b_r} + (RATE_W + 1)'(len_r);

  // Shared divider for both samples.
  assign div_num = (state_r == ST_CHECK) ? (NUM_W'(tps_eff) << RATE_FRAC_BITS)
                                         : NUM_W'(prod_r);
  assign div_den = (state_r == ST_CHECK) ? elapsed_c : elapsed_r;

  eprm_div #(
    .NUM_W (NUM_W),
    .DEN_W (TIME_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .sts   (div_sts),
    .quot  (div_q)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = to_div ? ST_DIV_P : ST_DONE;
      ST_DIV_P: if (div_sts.done) state_nxt = ST_DIV_D;
      ST_DIV_D: begin
        if (div_sts.done) state_nxt = direct_r ? ST_DONE : ST_EMA0;
      end
      ST_EMA0:  state_nxt = ST_EMA1;
      ST_EMA1:  state_nxt = ST_EMA2;
      ST_EMA2:  state_nxt = ST_EMA3;
      ST_EMA3:  state_nxt = ST_EMA4;
      ST_EMA4:  state_nxt = ST_DONE;
      ST_DONE:  if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, divider start and multiplier operands.
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    mul_a     = rate_p_r;
    mul_b     = a_inv;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_CHECK: div_start = to_div;
      ST_DIV_P: div_start = div_sts.done;
      ST_EMA1: begin
        mul_a = samp_p_r;
        mul_b = a_eff;
      end
      ST_EMA2: begin
        mul_a = rate_b_r;
        mul_b = a_inv;
      end
      ST_EMA3: begin
        mul_a = samp_d_r;
        mul_b = a_eff;
      end
      ST_DONE:  load_out = !out_tvalid_r || out_tready;
      default: begin
        mul_a = rate_p_r;
        mul_b = a_inv;
      end
    endcase
  end

  // Control state, configuration and meter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wgt_r        <= ALPHA_RESET;
      tps_r        <= TPS_RESET;
      seen_r       <= 1'b0;
      last_r       <= '0;
      rate_p_r     <= '0;
      rate_b_r     <= '0;
      pend_p_r     <= '0;
      pend_b_r     <= '0;
      sum_p_r      <= '0;
      sum_b_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SMOOTHING: wgt_r <= cfg_data[ALPHA_W-1:0];
          CFG_TPS:       tps_r <= cfg_data[TPS_W-1:0];
          default:       wgt_r <= wgt_r;
        endcase
      end

      unique case (state_r)
        ST_CHECK: begin
          if (!seen_r) begin
            // First arrival: rates are set directly, pending restarts.
            seen_r   <= 1'b1;
            last_r   <= now_r;
            pend_p_r <= PEND_P_W'(1);
            pend_b_r <= RATE_W'(len_r);
            if (now_r == '0) begin
              rate_p_r <= ONE_RATE;
              rate_b_r <= RATE_W'(len_r);
            end
          end else if (later) begin
            // Time advanced: fold pending counts into the totals.
            sum_p_r  <= sum_p_add[RATE_W] ? {RATE_W{1'b1}} : sum_p_add[RATE_W-1:0];
            sum_b_r  <= sum_b_add[RATE_W] ? {RATE_W{1'b1}} : sum_b_add[RATE_W-1:0];
            last_r   <= now_r;
            pend_p_r <= PEND_P_W'(1);
            pend_b_r <= RATE_W'(len_r);
          end else begin
            // Same or earlier timestamp: accumulate only.
            if (pend_p_r != {PEND_P_W{1'b1}}) pend_p_r <= pend_p_r + PEND_P_W'(1);
            pend_b_r <= pend_b_add[RATE_W] ? {RATE_W{1'b1}} : pend_b_add[RATE_W-1:0];
          end
        end
        ST_DIV_D: begin
          if (div_sts.done && direct_r) begin
            rate_p_r <= samp_p_r;
            rate_b_r <= div_q;
          end
        end
        ST_EMA2: rate_p_r <= mix[RATE_W+ALPHA_FRAC-1:ALPHA_FRAC];
        ST_EMA4: rate_b_r <= mix[RATE_W+ALPHA_FRAC-1:ALPHA_FRAC];
        default: rate_p_r <= rate_p_r;
      endcase

      // Output register holds a result until the beat is taken.
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      now_r <= in_tdata[TIME_WIDTH-1:0];
      len_r <= in_tdata[TIME_WIDTH+LEN_W-1:TIME_WIDTH];
    end
    if (state_r == ST_CHECK) begin
      elapsed_r <= elapsed_c;
      prod_r    <= PROD_W'(len_r) * PROD_W'(tps_eff);
      direct_r  <= !seen_r;
    end
    if (state_r == ST_DIV_P && div_sts.done) samp_p_r <= div_q;
    if (state_r == ST_DIV_D && div_sts.done) samp_d_r <= div_q;
    // Shared multiplier; the EMA sum is built over two products.
    mprod_r <= MUL_W'(mul_a) * MUL_W'(mul_b);
    if (state_r == ST_EMA1 || state_r == ST_EMA3) acc_r <= mprod_r;
    if (load_out) begin
      out_rp_r <= rate_p_r;
      out_rb_r <= rate_b_r;
      out_sp_r <= sum_p_r;
      out_sb_r <= sum_b_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_sb_r, out_sp_r, out_rb_r, out_rp_r};

`ifndef ASSERT_OFF
  // An accepted arrival closes the input until the item is finished.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in work");

  // The divider is never restarted while it is still stepping.
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  // A divider result only arrives while the sequencer waits for one.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == ST_DIV_P || state_r == ST_DIV_D))
    else $error("divider result outside a divide state");

  // After the first arrival at least the current packet is pending.
  a_pending_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r && state_r == ST_IDLE |-> pend_p_r != '0)
    else $error("pending packet count lost");

  // Folded totals never go down.
  a_totals_grow: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> sum_p_r >= $past(sum_p_r) && sum_b_r >= $past(sum_b_r))
    else $error("totals decreased");
`endif

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packet rate meter. Arrival beats are driven
// with random gaps while the result side stalls at random; a scoreboard
// class predicts both smoothed rates and both totals for every accepted
// arrival and compares each result beat field by field, across several
// register settings that include the extremes of both registers.
// ----------------------------------------------------------------------------
module tb;
  import eprm_pkg::*;

  localparam int TIME_W     = DEF_TIME_WIDTH;
  localparam int RATE_FRAC  = DEF_RATE_FRAC;
  localparam int IN_W       = ((TIME_W + LEN_W + 7) / 8) * 8;
  localparam int OUT_W      = 4 * RATE_W;

  localparam logic [63:0]     MAX48     = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0]     MAX32     = 64'hFFFF_FFFF;
  localparam logic [47:0]     STAMP_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_TOP  = '1;
  localparam logic [LEN_W-1:0] LEN_NOM  = 19'd524280;

  // Update latency of the block plus margin, and run limits.
  localparam int UPDATE_LATENCY = 112;
  localparam int HOLDOFF_CYCLES = 500;
  localparam int CYCLE_LIMIT    = 5_000_000;
  localparam int PHASE_ITEMS    = 305;

  // One result beat; the packed order matches out_tdata, lowest field last.
  typedef struct packed {
    logic [47:0] total_bits;
    logic [47:0] total_packets;
    logic [47:0] data_rate;
    logic [47:0] packet_rate;
  } rate_report_t;

  // Scoreboard: mirrors the meter state and holds the reports still owed.
  class rate_tracker;
    logic [ALPHA_W-1:0] alpha;
    logic [TPS_W-1:0]   tps;
    bit                 seen_first;
    logic [47:0]        last_stamp;
    logic [63:0]        pkt_rate, bit_rate;
    logic [63:0]        pend_pkts, pend_bits;
    logic [63:0]        total_pkts, total_bits;
    rate_report_t       expected_reports[$];
    int unsigned        fail_count;

    function new();
      alpha      = ALPHA_RESET;
      tps        = TPS_RESET;
      seen_first = 1'b0;
      last_stamp = '0;
      pkt_rate   = '0;
      bit_rate   = '0;
      pend_pkts  = '0;
      pend_bits  = '0;
      total_pkts = '0;
      total_bits = '0;
      fail_count = 0;
    endfunction

    function void set_register(eprm_cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_SMOOTHING: alpha = value[ALPHA_W-1:0];
        CFG_TPS:       tps   = value[TPS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] clamp48(logic [63:0] v);
      return (v > MAX48) ? MAX48 : v;
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] top);
      logic [63:0] s;
      s = a + b;
      return (s > top || s < a) ? top : s;
    endfunction

    function logic [63:0] ticks_eff();
      return (tps == '0) ? 64'd1 : 64'(tps);
    endfunction

    // Packets per second in Q32.RATE_FRAC for one packet over the interval.
    function logic [63:0] pkts_per_second(logic [63:0] elapsed);
      return clamp48((ticks_eff() << RATE_FRAC) / elapsed);
    endfunction

    // Bits per second for the current packet over the interval.
    function logic [63:0] bits_per_second(logic [63:0] len, logic [63:0] elapsed);
      return clamp48((len * ticks_eff()) / elapsed);
    endfunction

    // Move the old rate toward the target by alpha, alpha capped at one.
    function logic [63:0] smooth(logic [63:0] old, logic [63:0] target);
      logic [63:0] a;
      logic [63:0] mix;
      a   = (alpha > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha);
      mix = old * (64'(ALPHA_ONE) - a) + target * a;
      return clamp48(mix >> 16);
    endfunction

    function void note_arrival(logic [47:0] stamp, logic [LEN_W-1:0] len);
      logic [63:0]  elapsed;
      logic [63:0]  len64;
      rate_report_t report;
      len64 = 64'(len);
      if (!seen_first) begin
        // The first arrival sets the rates directly.
        if (stamp == '0) begin
          pkt_rate = clamp48(64'd1 << RATE_FRAC);
          bit_rate = len64;
        end else begin
          pkt_rate = pkts_per_second(64'(stamp));
          bit_rate = bits_per_second(len64, 64'(stamp));
        end
        pend_pkts  = '0;
        pend_bits  = '0;
        last_stamp = stamp;
        seen_first = 1'b1;
      end else if (stamp > last_stamp) begin
        elapsed    = 64'(stamp - last_stamp);
        total_pkts = sat_add(total_pkts, pend_pkts, MAX48);
        total_bits = sat_add(total_bits, pend_bits, MAX48);
        pkt_rate   = smooth(pkt_rate, pkts_per_second(elapsed));
        bit_rate   = smooth(bit_rate, bits_per_second(len64, elapsed));
        pend_pkts  = '0;
        pend_bits  = '0;
        last_stamp = stamp;
      end
      pend_pkts = sat_add(pend_pkts, 64'd1, MAX32);
      pend_bits = sat_add(pend_bits, len64, MAX48);

      report.packet_rate   = pkt_rate[47:0];
      report.data_rate     = bit_rate[47:0];
      report.total_packets = total_pkts[47:0];
      report.total_bits    = total_bits[47:0];
      expected_reports.push_back(report);
    endfunction

    function void check_report(logic [OUT_W-1:0] beat);
      logic [OUT_W-1:0] want;
      string            names[4];
      if (expected_reports.size() == 0) begin
        $error("result beat with no expectation waiting: %h", beat);
        fail_count++;
        return;
      end
      want  = expected_reports.pop_front();
      names = '{"packet_rate", "data_rate", "total_packets", "total_bits"};
      for (int i = 0; i < 4; i++) begin
        if (beat[i*RATE_W +: RATE_W] !== want[i*RATE_W +: RATE_W]) begin
          $error("%s mismatch: expected %0d, actual %0d", names[i],
                 want[i*RATE_W +: RATE_W], beat[i*RATE_W +: RATE_W]);
          fail_count++;
        end
      end
    endfunction

    function int unsigned waiting();
      return expected_reports.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_W-1:0]       out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rate_tracker tracker = new();
  logic [47:0] tick_now;
  int          no_gap_left;
  int          holdoff_requests;
  int          holdoffs_done;

  ema_packet_rate_meter #(
    .TIME_WIDTH     (TIME_W),
    .RATE_FRAC_BITS (RATE_FRAC)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ema_packet_rate_meter verification failed");
    $finish;
  end

  // Every result beat is checked against the oldest expected report.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_report(out_tdata);
    end
  end

  // Result side: random stalls, stretches of steady ready, and long
  // hold-offs on request so the meter backs up into its input.
  task automatic hold_ready(input logic value, input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      out_tready <= value;
    end
  endtask

  initial begin : result_sink
    int unsigned r;
    out_tready    = 1'b0;
    holdoffs_done = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (holdoffs_done < holdoff_requests) begin
        hold_ready(1'b0, HOLDOFF_CYCLES);
        holdoffs_done++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          hold_ready(1'b1, $urandom_range(20, 200));
        end else begin
          hold_ready(1'b0, (r < 31) ? $urandom_range(20, 150) : $urandom_range(1, 3));
          hold_ready(1'b1, $urandom_range(1, 8));
        end
      end
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // Next timestamp: mostly forward steps, some repeats and some earlier ones.
  function automatic logic [47:0] pick_stamp();
    int unsigned r;
    logic [47:0] room;
    logic [47:0] step;
    r    = $urandom_range(0, 99);
    room = STAMP_MAX - tick_now;
    if (r < 60) begin
      step = 48'($urandom_range(1, 1000));
    end else if (r < 72) begin
      step = 48'($urandom_range(1001, 1 << 20));
    end else if (r < 77) begin
      step = 48'd1;
    end else if (r < 79) begin
      step = rand48() % (room / 2 + 48'd1) + 48'd1;
    end else if (r < 91) begin
      step = '0;
    end else begin
      return 48'(rand48() % ({1'b0, tick_now} + 49'd1));
    end
    if (step > room) begin
      step = room;
    end
    tick_now = tick_now + step;
    return tick_now;
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)      return LEN_W'($urandom_range(512, 12000));
    else if (r < 80) return LEN_W'($urandom_range(0, LEN_TOP));
    else if (r < 88) return '0;
    else if (r < 94) return LEN_NOM;
    else             return LEN_TOP;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45)      return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 20);
    else             return $urandom_range(40, 250);
  endfunction

  // Offer one arrival beat and wait for its handshake.
  task automatic send_arrival(input logic [47:0] stamp, input logic [LEN_W-1:0] len);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({len, stamp});
    do @(posedge clk); while (!in_tready);
    tracker.note_arrival(stamp, len);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every expected report has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
  endtask

  task automatic write_register(input eprm_cfg_idx_t idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    tracker.set_register(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One register setting: edge beats, then random arrivals with an optional hold-off or pause halfway.
  task automatic run_phase(input int items, input bit with_holdoff, input bit with_pause);
    int gap;
    // Shortest interval with the longest packet, then a zero-length repeat.
    if (tick_now < STAMP_MAX) tick_now = tick_now + 48'd1;
    send_arrival(tick_now, LEN_TOP);
    send_arrival(tick_now, '0);
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) begin
        if (with_holdoff) begin
          holdoff_requests++;
          no_gap_left = 40;
        end
        if (with_pause) drain_results();
      end
      if (i % 64 == 0 && $urandom_range(0, 3) == 0) no_gap_left = 32;
      if (no_gap_left > 0) begin
        no_gap_left--;
        gap = 0;
      end else begin
        gap = pick_gap();
      end
      idle_sender(gap);
      send_arrival(pick_stamp(), pick_length());
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_SMOOTHING;
    cfg_data         = '0;
    tick_now         = '0;
    no_gap_left      = 0;
    holdoff_requests = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Opening beats at reset settings: the first arrival lands at tick zero
    // or later, then a repeat, an earlier stamp and a long interval.
    tick_now = ($urandom_range(0, 1) == 0) ? 48'd0 : 48'($urandom_range(1, 5000));
    send_arrival(tick_now, 19'd12000);
    send_arrival(tick_now, '0);
    tick_now = tick_now + 48'd1;
    send_arrival(tick_now, LEN_TOP);
    tick_now = tick_now + 48'd1000;
    send_arrival(tick_now, '0);
    send_arrival(tick_now - 48'd500, 19'd800);
    tick_now = tick_now + 48'd2_000_000;
    send_arrival(tick_now, 19'd4000);
    tick_now = tick_now + 48'd1;
    send_arrival(tick_now, LEN_NOM);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    // Alpha zero freezes the rates; one tick per second.
    drain_results();
    write_register(CFG_SMOOTHING, 32'd0);
    write_register(CFG_TPS, 32'd1);
    run_phase(PHASE_ITEMS, 1'b0, 1'b1);

    // Alpha one and the fastest tick rate: data-rate samples saturate for long packets.
    drain_results();
    write_register(CFG_SMOOTHING, 32'(ALPHA_ONE));
    write_register(CFG_TPS, 32'hFFFF_FFFF);
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);

    // Alpha above one and a zero tick rate.
    drain_results();
    write_register(CFG_SMOOTHING, 32'h1FFFF);
    write_register(CFG_TPS, 32'd0);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    drain_results();
    write_register(CFG_SMOOTHING, 32'(ALPHA_ONE) + 32'd1);
    write_register(CFG_TPS, 32'd1000);
    run_phase(PHASE_ITEMS, 1'b1, 1'b1);

    drain_results();
    write_register(CFG_SMOOTHING, 32'($urandom_range(0, 32'h1FFFF)));
    write_register(CFG_TPS, $urandom);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    // Top of the timestamp range, then a repeat and a stamp far behind.
    send_arrival(STAMP_MAX - 48'd1, pick_length());
    send_arrival(STAMP_MAX, pick_length());
    send_arrival(STAMP_MAX, '0);
    send_arrival('0, LEN_TOP);
    tick_now = STAMP_MAX;

    drain_results();
    repeat (UPDATE_LATENCY + 40) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.waiting() == 0) begin
      $display("ema_packet_rate_meter verification clean");
    end else begin
      $display("ema_packet_rate_meter verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/eprm_pkg.sv
rtl/eprm_div.sv
rtl/ema_packet_rate_meter.sv
bench/tb.sv
